// File: hw/rtl/yab_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the anchor box decoder.
// No dependencies; imported by yab_front, yab_geom, yolo_anchor_box_decode, yab_box_checker and tb.

package yab_pkg;

    // Field widths of the input and result beats.
    localparam int GRID_W       = 7;
    localparam int SLOT_W       = 2;
    localparam int RAW_W        = 8;
    localparam int SCALE_W      = 16;
    localparam int SHIFT_W      = 3;
    localparam int ANCHOR_REG_W = 60;
    localparam int EDGE_W       = 18;
    localparam int SIZE_W       = 16;
    localparam int SCORE_W      = 17;

    // Grid limit and the default anchor field width.
    localparam int GRID_CMP_W      = 9;
    localparam int MAX_GRID        = 128;
    localparam int ANCHOR_BITS_DEF = 10;

    // Sigmoid output, 16 fractional bits, 0.0 .. 1.0.
    localparam int SIG_W = 17;

    // Valid stride shifts are 3 to 5.
    localparam logic [SHIFT_W-1:0] STRIDE_SHIFT_MIN = 3'd3;
    localparam logic [SHIFT_W-1:0] STRIDE_SHIFT_MAX = 3'd5;

    // Register indexes of the configuration channel.
    typedef enum logic [2:0] {
        CFG_ZERO_POINT    = 3'd0,
        CFG_DEQUANT_SCALE = 3'd1,
        CFG_CONF_THRESH   = 3'd2,
        CFG_STRIDE_SHIFT  = 3'd3,
        CFG_ANCHOR_SIZES  = 3'd4
    } cfg_idx_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [RAW_W-1:0]   zero_point;
        logic [SCALE_W-1:0]        dequant_scale;
        logic signed [RAW_W-1:0]   conf_threshold_q;
        logic [SHIFT_W-1:0]        stride_shift;
        logic [ANCHOR_REG_W-1:0]   anchor_sizes;
    } cfg_t;

    // One input beat after unpacking.
    typedef struct packed {
        logic [GRID_W-1:0]       grid_row;
        logic [GRID_W-1:0]       grid_col;
        logic [SLOT_W-1:0]       anchor_slot;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_w;
        logic signed [RAW_W-1:0] raw_h;
        logic signed [RAW_W-1:0] raw_objectness;
        logic signed [RAW_W-1:0] raw_class;
    } raw_item_t;

    // Item between the sigmoid half and the geometry half.
    typedef struct packed {
        logic [GRID_W-1:0] grid_row;
        logic [GRID_W-1:0] grid_col;
        logic [SLOT_W-1:0] anchor_slot;
        logic [SIG_W-1:0]  s_x;
        logic [SIG_W-1:0]  s_y;
        logic [SIG_W-1:0]  s_w;
        logic [SIG_W-1:0]  s_h;
        logic [SIG_W-1:0]  s_obj;
        logic [SIG_W-1:0]  s_cls;
    } sig_item_t;

    // Result beat; the last member sits in the lowest bits.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [SIZE_W-1:0]  box_height;
        logic [SIZE_W-1:0]  box_width;
        logic [EDGE_W-1:0]  top_y;
        logic [EDGE_W-1:0]  left_x;
    } box_t;

endpackage

// File: hw/rtl/yab_front.sv
`timescale 1ns / 1ps
// Front half of the decoder: anchor slot and threshold filter, dequantization and PLAN sigmoid.
// Two pipeline stages. Depends on yab_pkg.

module yab_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  yab_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  yab_pkg::raw_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output yab_pkg::sig_item_t out_item
);
    import yab_pkg::*;

    localparam int NUM_LOGITS = 6;
    // (q - zero_point) is 9 bits signed, the scale 17 bits as a signed operand.
    localparam int DIFF_W = RAW_W + 1;
    localparam int DQ_W   = DIFF_W + SCALE_W + 1;

    localparam logic [DQ_W-1:0]  KNEE_SAT  = DQ_W'(327680);
    localparam logic [DQ_W-1:0]  KNEE_HIGH = DQ_W'(155648);
    localparam logic [DQ_W-1:0]  KNEE_MID  = DQ_W'(65536);
    localparam logic [SIG_W-1:0] SIG_ONE   = SIG_W'(65536);
    localparam logic [SIG_W-1:0] OFS_HIGH  = SIG_W'(55296);
    localparam logic [SIG_W-1:0] OFS_MID   = SIG_W'(40960);
    localparam logic [SIG_W-1:0] OFS_LOW   = SIG_W'(32768);

    // PLAN piecewise-linear sigmoid on a Q16 value; shifts truncate.
    function automatic logic [SIG_W-1:0] plan_sigmoid(input logic signed [DQ_W-1:0] v);
        logic [DQ_W-1:0]  a;
        logic [SIG_W-1:0] p;
        a = v[DQ_W-1] ? DQ_W'(-v) : DQ_W'(v);
        if (a >= KNEE_SAT) begin
            p = SIG_ONE;
        end else if (a >= KNEE_HIGH) begin
            p = SIG_W'(a >> 5) + OFS_HIGH;
        end else if (a >= KNEE_MID) begin
            p = SIG_W'(a >> 3) + OFS_MID;
        end else begin
            p = SIG_W'(a >> 2) + OFS_LOW;
        end
        return v[DQ_W-1] ? SIG_ONE - p : p;
    endfunction

    logic                     pass;
    logic signed [RAW_W-1:0]  raw_arr [NUM_LOGITS];
    logic signed [DQ_W-1:0]   dq_next [NUM_LOGITS];
    logic                     st1_ready;
    logic                     st2_ready;

    logic                     st1_vld_reg;
    logic [GRID_W-1:0]        st1_row_reg;
    logic [GRID_W-1:0]        st1_col_reg;
    logic [SLOT_W-1:0]        st1_slot_reg;
    logic signed [DQ_W-1:0]   st1_dq_reg [NUM_LOGITS];

    logic                     st2_vld_reg;
    sig_item_t                st2_item_reg;

    // Items that fail the filter are accepted and simply never enter the pipe.
    assign pass = (in_item.anchor_slot != 2'd3)
               && (GRID_CMP_W'(in_item.grid_row) < GRID_CMP_W'(MAX_GRID))
               && (GRID_CMP_W'(in_item.grid_col) < GRID_CMP_W'(MAX_GRID))
               && (in_item.raw_objectness >= cfg.conf_threshold_q)
               && (in_item.raw_class > cfg.conf_threshold_q);

    assign raw_arr[0] = in_item.raw_x;
    assign raw_arr[1] = in_item.raw_y;
    assign raw_arr[2] = in_item.raw_w;
    assign raw_arr[3] = in_item.raw_h;
    assign raw_arr[4] = in_item.raw_objectness;
    assign raw_arr[5] = in_item.raw_class;

    // Dequantize: one 9 x 17 signed multiply per logit.
    always_comb begin
        for (int i = 0; i < NUM_LOGITS; i++) begin
            dq_next[i] = DQ_W'(DIFF_W'(raw_arr[i]) - DIFF_W'(cfg.zero_point))
                       * $signed({1'b0, cfg.dequant_scale});
        end
    end

    // A stage takes a new beat when it is empty or its content moves on.
    assign st2_ready = !st2_vld_reg || out_ready;
    assign st1_ready = !st1_vld_reg || st2_ready;
    assign in_ready  = st1_ready;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_vld_reg <= in_valid && pass;
            end
            if (st2_ready) begin
                st2_vld_reg <= st1_vld_reg;
            end
        end
    end

    // Stage 1: dequantized logits.
    always_ff @(posedge aclk) begin
        if (st1_ready && in_valid) begin
            st1_row_reg  <= in_item.grid_row;
            st1_col_reg  <= in_item.grid_col;
            st1_slot_reg <= in_item.anchor_slot;
            for (int i = 0; i < NUM_LOGITS; i++) begin
                st1_dq_reg[i] <= dq_next[i];
            end
        end
    end

    // Stage 2: sigmoids.
    always_ff @(posedge aclk) begin
        if (st2_ready && st1_vld_reg) begin
            st2_item_reg.grid_row    <= st1_row_reg;
            st2_item_reg.grid_col    <= st1_col_reg;
            st2_item_reg.anchor_slot <= st1_slot_reg;
            st2_item_reg.s_x         <= plan_sigmoid(st1_dq_reg[0]);
            st2_item_reg.s_y         <= plan_sigmoid(st1_dq_reg[1]);
            st2_item_reg.s_w         <= plan_sigmoid(st1_dq_reg[2]);
            st2_item_reg.s_h         <= plan_sigmoid(st1_dq_reg[3]);
            st2_item_reg.s_obj       <= plan_sigmoid(st1_dq_reg[4]);
            st2_item_reg.s_cls       <= plan_sigmoid(st1_dq_reg[5]);
        end
    end

    assign out_valid = st2_vld_reg;
    assign out_item  = st2_item_reg;

endmodule

// File: hw/rtl/yab_geom.sv
`timescale 1ns / 1ps
// Back half of the decoder: box sizes and edges in 1/16 pixel, and the score.
// Three pipeline stages, the last one is the output register. Depends on yab_pkg.

module yab_geom #(
    parameter int ANCHOR_BITS = yab_pkg::ANCHOR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  yab_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  yab_pkg::sig_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output yab_pkg::box_t      out_box
);
    import yab_pkg::*;

    // (2s)^2 needs 35 bits, the size in pixels with 32 fractional bits more.
    localparam int TW_W   = SIG_W + 1;
    localparam int SQ_W   = 2 * SIG_W + 1;
    localparam int W32_W  = SQ_W + ANCHOR_BITS;
    // Center in Q16 pixels of the cell grid, then scaled by the stride.
    localparam int C_W    = GRID_W + 18;
    localparam int CS_W   = C_W + 5;
    localparam int E_W    = CS_W + 18;
    localparam int PROD_W = 2 * SIG_W;
    localparam int EDGE_LSB  = 29;
    localparam int SIZE_LSB  = 28;
    localparam int SCORE_LSB = 16;
    localparam logic [C_W-1:0] HALF_Q16 = C_W'(32768);

    logic st3_ready;
    logic st4_ready;
    logic st5_ready;

    logic [SHIFT_W-1:0]     sh_clamped;
    logic [1:0]             sh_ofs_next;
    logic [ANCHOR_BITS-1:0] aw_next;
    logic [ANCHOR_BITS-1:0] ah_next;
    logic [TW_W-1:0]        tw_w;
    logic [TW_W-1:0]        tw_h;

    // Stage 3 registers.
    logic                   st3_vld_reg;
    logic [SQ_W-1:0]        st3_sqw_reg;
    logic [SQ_W-1:0]        st3_sqh_reg;
    logic signed [C_W-1:0]  st3_cx_reg;
    logic signed [C_W-1:0]  st3_cy_reg;
    logic [PROD_W-1:0]      st3_prod_reg;
    logic [ANCHOR_BITS-1:0] st3_aw_reg;
    logic [ANCHOR_BITS-1:0] st3_ah_reg;
    logic [1:0]             st3_sh_reg;

    // Stage 4 registers.
    logic                   st4_vld_reg;
    logic [W32_W-1:0]       st4_w32_reg;
    logic [W32_W-1:0]       st4_h32_reg;
    logic signed [CS_W-1:0] st4_cx_reg;
    logic signed [CS_W-1:0] st4_cy_reg;
    logic [SCORE_W-1:0]     st4_score_reg;

    // Stage 5 (output) registers.
    logic                   st5_vld_reg;
    box_t                   st5_box_reg;

    logic signed [CS_W-1:0] cx_sh_next;
    logic signed [CS_W-1:0] cy_sh_next;
    logic signed [E_W-1:0]  w_ext;
    logic signed [E_W-1:0]  h_ext;
    logic signed [E_W-1:0]  ex_next;
    logic signed [E_W-1:0]  ey_next;

    assign st5_ready = !st5_vld_reg || out_ready;
    assign st4_ready = !st4_vld_reg || st5_ready;
    assign st3_ready = !st3_vld_reg || st4_ready;
    assign in_ready  = st3_ready;

    // Stride shift held to 3..5, kept as an offset from 3.
    always_comb begin
        if (cfg.stride_shift < STRIDE_SHIFT_MIN) begin
            sh_clamped = STRIDE_SHIFT_MIN;
        end else if (cfg.stride_shift > STRIDE_SHIFT_MAX) begin
            sh_clamped = STRIDE_SHIFT_MAX;
        end else begin
            sh_clamped = cfg.stride_shift;
        end
        sh_ofs_next = 2'(sh_clamped - STRIDE_SHIFT_MIN);
    end

    // Anchor pair of the slot; only slots 0..2 reach this point.
    always_comb begin
        unique case (in_item.anchor_slot)
            2'd0: begin
                aw_next = cfg.anchor_sizes[0 * ANCHOR_BITS +: ANCHOR_BITS];
                ah_next = cfg.anchor_sizes[1 * ANCHOR_BITS +: ANCHOR_BITS];
            end
            2'd1: begin
                aw_next = cfg.anchor_sizes[2 * ANCHOR_BITS +: ANCHOR_BITS];
                ah_next = cfg.anchor_sizes[3 * ANCHOR_BITS +: ANCHOR_BITS];
            end
            default: begin
                aw_next = cfg.anchor_sizes[4 * ANCHOR_BITS +: ANCHOR_BITS];
                ah_next = cfg.anchor_sizes[5 * ANCHOR_BITS +: ANCHOR_BITS];
            end
        endcase
    end

    assign tw_w = {in_item.s_w, 1'b0};
    assign tw_h = {in_item.s_h, 1'b0};

    // Center times the stride.
    always_comb begin
        case (st3_sh_reg)
            2'd0:    begin
                cx_sh_next = CS_W'(st3_cx_reg) <<< 3;
                cy_sh_next = CS_W'(st3_cy_reg) <<< 3;
            end
            2'd1:    begin
                cx_sh_next = CS_W'(st3_cx_reg) <<< 4;
                cy_sh_next = CS_W'(st3_cy_reg) <<< 4;
            end
            default: begin
                cx_sh_next = CS_W'(st3_cx_reg) <<< 5;
                cy_sh_next = CS_W'(st3_cy_reg) <<< 5;
            end
        endcase
    end

    // Edge = center - size/2, with 33 fractional bits; floor by taking the upper bits.
    always_comb begin
        w_ext   = E_W'(st4_w32_reg);
        h_ext   = E_W'(st4_h32_reg);
        ex_next = (E_W'(st4_cx_reg) <<< 17) - w_ext;
        ey_next = (E_W'(st4_cy_reg) <<< 17) - h_ext;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_vld_reg <= 1'b0;
            st4_vld_reg <= 1'b0;
            st5_vld_reg <= 1'b0;
        end else begin
            if (st3_ready) begin
                st3_vld_reg <= in_valid;
            end
            if (st4_ready) begin
                st4_vld_reg <= st3_vld_reg;
            end
            if (st5_ready) begin
                st5_vld_reg <= st4_vld_reg;
            end
        end
    end

    // Stage 3: squares of 2s, centers in Q16, score product.
    always_ff @(posedge aclk) begin
        if (st3_ready && in_valid) begin
            st3_sqw_reg  <= SQ_W'(tw_w) * SQ_W'(tw_w);
            st3_sqh_reg  <= SQ_W'(tw_h) * SQ_W'(tw_h);
            st3_cx_reg   <= C_W'({in_item.s_x, 1'b0}) + C_W'({in_item.grid_col, 16'b0})
                          - HALF_Q16;
            st3_cy_reg   <= C_W'({in_item.s_y, 1'b0}) + C_W'({in_item.grid_row, 16'b0})
                          - HALF_Q16;
            st3_prod_reg <= in_item.s_cls * in_item.s_obj;
            st3_aw_reg   <= aw_next;
            st3_ah_reg   <= ah_next;
            st3_sh_reg   <= sh_ofs_next;
        end
    end

    // Stage 4: sizes in Q32 pixels, scaled centers, score.
    always_ff @(posedge aclk) begin
        if (st4_ready && st3_vld_reg) begin
            st4_w32_reg   <= st3_sqw_reg * st3_aw_reg;
            st4_h32_reg   <= st3_sqh_reg * st3_ah_reg;
            st4_cx_reg    <= cx_sh_next;
            st4_cy_reg    <= cy_sh_next;
            st4_score_reg <= st3_prod_reg[SCORE_LSB +: SCORE_W];
        end
    end

    // Stage 5: edges and output register.
    always_ff @(posedge aclk) begin
        if (st5_ready && st4_vld_reg) begin
            st5_box_reg.left_x     <= ex_next[EDGE_LSB +: EDGE_W];
            st5_box_reg.top_y      <= ey_next[EDGE_LSB +: EDGE_W];
            st5_box_reg.box_width  <= w_ext[SIZE_LSB +: SIZE_W];
            st5_box_reg.box_height <= h_ext[SIZE_LSB +: SIZE_W];
            st5_box_reg.score      <= st4_score_reg;
        end
    end

    assign out_valid = st5_vld_reg;
    assign out_box   = st5_box_reg;

endmodule

// File: hw/rtl/yolo_anchor_box_decode.sv
`timescale 1ns / 1ps
// Top level of the anchor box decoder: stream ports, configuration registers.
// Instantiates yab_front and yab_geom; depends on yab_pkg.
//
//  Channel  Direction  Beat contents
//  -------  ---------  -------------------------------------------------------
//  s_       in         one cell and anchor slot: six int8 logits, row, column
//  m_       out        one box: edges, size, score (none for filtered items)
//  cfg_     in         one register write: index and data
//
// Throughput is one beat per cycle while m_ does not stall; a result passes the
// pipeline stages of yab_front (two) and of yab_geom (three).
// Reset clears every stage valid bit and loads the register reset values.
// Every stage holds its beat while the next one is full, so a stall on m_
// reaches s_tready only once all five stages are occupied.

module yolo_anchor_box_decode #(
    parameter int ANCHOR_BITS = yab_pkg::ANCHOR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: grid_row[6:0], grid_col[6:0], raw_x, raw_y, raw_w,
    // raw_h, raw_objectness, raw_class (8 each), two zero bits.
    input  logic [63:0] s_tdata,
    // s_tuser: anchor_slot[1:0].
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: left_x[17:0], top_y[17:0], box_width[15:0],
    // box_height[15:0], score[16:0], three zero bits.
    output logic [87:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data
);
    import yab_pkg::*;

    cfg_t      cfg_reg;
    raw_item_t in_item;
    sig_item_t mid_item;
    logic      mid_valid;
    logic      mid_ready;
    box_t      out_box;

    // Configuration register writes; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_point       <= '0;
            cfg_reg.dequant_scale    <= SCALE_W'(4096);
            cfg_reg.conf_threshold_q <= '0;
            cfg_reg.stride_shift     <= STRIDE_SHIFT_MIN;
            cfg_reg.anchor_sizes     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ZERO_POINT:    cfg_reg.zero_point       <= cfg_data[RAW_W-1:0];
                CFG_DEQUANT_SCALE: cfg_reg.dequant_scale    <= cfg_data[SCALE_W-1:0];
                CFG_CONF_THRESH:   cfg_reg.conf_threshold_q <= cfg_data[RAW_W-1:0];
                CFG_STRIDE_SHIFT:  cfg_reg.stride_shift     <= cfg_data[SHIFT_W-1:0];
                CFG_ANCHOR_SIZES:  cfg_reg.anchor_sizes     <= cfg_data[ANCHOR_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat.
    assign in_item.grid_row       = s_tdata[6:0];
    assign in_item.grid_col       = s_tdata[13:7];
    assign in_item.anchor_slot    = s_tuser;
    assign in_item.raw_x          = s_tdata[21:14];
    assign in_item.raw_y          = s_tdata[29:22];
    assign in_item.raw_w          = s_tdata[37:30];
    assign in_item.raw_h          = s_tdata[45:38];
    assign in_item.raw_objectness = s_tdata[53:46];
    assign in_item.raw_class      = s_tdata[61:54];

    yab_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    yab_geom #(
        .ANCHOR_BITS (ANCHOR_BITS)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_box   (out_box)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, out_box};

    // A ready sink frees every stage, so the input side must be ready too.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low although the result side is ready");

    // The score is a product of two values in 0..1 and never exceeds 1.0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[84:68] <= 17'd65536))
        else $error("score above 1.0");

endmodule

// File: dv/yab_box_checker.sv
`timescale 1ns / 1ps
// Box checker for the anchor box decoder: tracks register writes, predicts the
// box of every accepted beat that passes the filters and compares result beats field by field.
// Depends on yab_pkg for field widths, register indexes and the box layout.

module yab_box_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [59:0] cfg_data,
    output int          fails,
    output int          pending
);
    import yab_pkg::*;

    // Local copy of the configuration registers.
    logic signed [RAW_W-1:0]  cur_zero_point;
    logic [SCALE_W-1:0]       cur_scale;
    logic signed [RAW_W-1:0]  cur_thresh;
    logic [SHIFT_W-1:0]       cur_shift;
    logic [ANCHOR_REG_W-1:0]  cur_anchors;

    // Boxes predicted but not yet seen on the result channel, oldest first.
    box_t boxes_due[$];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        fails++;
    endtask

    // Dequantize a logit and apply the piecewise-linear sigmoid (16 fraction bits).
    function automatic logic [SIG_W-1:0] plan_sigmoid(input logic signed [RAW_W-1:0] q);
        int v;
        int a;
        int p;
        v = (int'(q) - int'(cur_zero_point)) * int'(cur_scale);
        a = (v < 0) ? -v : v;
        if (a >= 327680)
            p = 65536;
        else if (a >= 155648)
            p = (a >>> 5) + 55296;
        else if (a >= 65536)
            p = (a >>> 3) + 40960;
        else
            p = (a >>> 2) + 32768;
        return SIG_W'((v < 0) ? 65536 - p : p);
    endfunction

    // Left or top edge in sixteenths of a pixel, floored once at the end.
    // size_q32 is the box size in pixels with 32 fraction bits.
    function automatic logic [EDGE_W-1:0] box_corner(input logic [SIG_W-1:0] s,
                                                     input logic [GRID_W-1:0] grid_idx,
                                                     input int shift,
                                                     input longint size_q32);
        longint center;
        longint pos;
        center = 2 * longint'(s) - 32768 + (longint'(grid_idx) <<< 16);
        center = center * (longint'(1) <<< shift);
        pos = (center * 131072 - size_q32) >>> 29;
        return pos[EDGE_W-1:0];
    endfunction

    // Work out the box for one input beat, if it passes the filters.
    task automatic predict_box(input logic [63:0] d, input logic [SLOT_W-1:0] slot);
        raw_item_t it;
        box_t bx;
        logic [SIG_W-1:0] sx, sy, sw, sh, so, sc;
        int shift;
        longint aw, ah, tw, th, w32, h32, prod;
        it.grid_row       = d[6:0];
        it.grid_col       = d[13:7];
        it.raw_x          = d[21:14];
        it.raw_y          = d[29:22];
        it.raw_w          = d[37:30];
        it.raw_h          = d[45:38];
        it.raw_objectness = d[53:46];
        it.raw_class      = d[61:54];
        it.anchor_slot    = slot;

        if (slot > 2 || int'(it.grid_row) >= MAX_GRID || int'(it.grid_col) >= MAX_GRID)
            return;
        if (!($signed(it.raw_objectness) >= cur_thresh && $signed(it.raw_class) > cur_thresh))
            return;

        // Stride shifts outside 3..5 are clamped.
        if (cur_shift < STRIDE_SHIFT_MIN)
            shift = int'(STRIDE_SHIFT_MIN);
        else if (cur_shift > STRIDE_SHIFT_MAX)
            shift = int'(STRIDE_SHIFT_MAX);
        else
            shift = int'(cur_shift);

        aw = longint'(cur_anchors[2 * slot * ANCHOR_BITS_DEF +: ANCHOR_BITS_DEF]);
        ah = longint'(cur_anchors[(2 * slot + 1) * ANCHOR_BITS_DEF +: ANCHOR_BITS_DEF]);

        sx = plan_sigmoid(it.raw_x);
        sy = plan_sigmoid(it.raw_y);
        sw = plan_sigmoid(it.raw_w);
        sh = plan_sigmoid(it.raw_h);
        so = plan_sigmoid(it.raw_objectness);
        sc = plan_sigmoid(it.raw_class);

        tw   = 2 * longint'(sw);
        th   = 2 * longint'(sh);
        w32  = tw * tw * aw;
        h32  = th * th * ah;
        prod = longint'(sc) * longint'(so);

        bx.left_x     = box_corner(sx, it.grid_col, shift, w32);
        bx.top_y      = box_corner(sy, it.grid_row, shift, h32);
        bx.box_width  = w32[43:28];
        bx.box_height = h32[43:28];
        bx.score      = prod[32:16];
        boxes_due = {boxes_due, bx};
    endtask

    // Compare one result beat with the oldest predicted box.
    task automatic check_box(input box_t got);
        box_t want;
        if (boxes_due.size() == 0) begin
            report_mismatch($sformatf("result beat with no box expected: %h", got));
            return;
        end
        want = boxes_due.pop_front();
        if (got.left_x !== want.left_x)
            report_mismatch($sformatf("left_x got %h expected %h", got.left_x, want.left_x));
        if (got.top_y !== want.top_y)
            report_mismatch($sformatf("top_y got %h expected %h", got.top_y, want.top_y));
        if (got.box_width !== want.box_width)
            report_mismatch($sformatf("box_width got %h expected %h",
                                      got.box_width, want.box_width));
        if (got.box_height !== want.box_height)
            report_mismatch($sformatf("box_height got %h expected %h",
                                      got.box_height, want.box_height));
        if (got.score !== want.score)
            report_mismatch($sformatf("score got %h expected %h", got.score, want.score));
    endtask

    // Sample all three channels at the clock edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_zero_point = '0;
            cur_scale      = 16'd4096;
            cur_thresh     = '0;
            cur_shift      = STRIDE_SHIFT_MIN;
            cur_anchors    = '0;
            fails          = 0;
            boxes_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ZERO_POINT:    cur_zero_point = cfg_data[RAW_W-1:0];
                    CFG_DEQUANT_SCALE: cur_scale      = cfg_data[SCALE_W-1:0];
                    CFG_CONF_THRESH:   cur_thresh     = cfg_data[RAW_W-1:0];
                    CFG_STRIDE_SHIFT:  cur_shift      = cfg_data[SHIFT_W-1:0];
                    CFG_ANCHOR_SIZES:  cur_anchors    = cfg_data[ANCHOR_REG_W-1:0];
                    default: ;
                endcase
            end
            // Retire the result first: it always belongs to an older input beat.
            if (m_tvalid && m_tready)
                check_box(box_t'(m_tdata[$bits(box_t)-1:0]));
            if (s_tvalid && s_tready)
                predict_box(s_tdata, s_tuser);
        end
        pending = boxes_due.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the anchor box decoder: clock, reset, register writes,
// directed and random input beats, random result back-pressure and the verdict.
// Depends on yab_pkg, yolo_anchor_box_decode and yab_box_checker.

module tb;
    import yab_pkg::*;

    localparam int SETTLE_CYCLES   = 12;
    localparam int LONG_HOLD       = 200;
    localparam int IDLE_LIMIT      = 1500;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES      = 8;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_data;

    int  fails;
    int  pending;
    int  idle_cycles = 0;
    bit  dense = 1'b0;
    bit  hold_req = 1'b0;
    logic signed [RAW_W-1:0] thr_now = '0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    yolo_anchor_box_decode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    yab_box_checker box_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Idle cycles before a beat; dense phases mostly send back to back.
    function automatic int draw_gap();
        if (dense && $urandom_range(0, 7) != 0)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic raw_item_t make_cell(input int row, input int col, input int slot,
                                            input int x, input int y, input int w,
                                            input int h, input int obj, input int cls);
        raw_item_t it;
        it.grid_row       = GRID_W'(row);
        it.grid_col       = GRID_W'(col);
        it.anchor_slot    = SLOT_W'(slot);
        it.raw_x          = RAW_W'(x);
        it.raw_y          = RAW_W'(y);
        it.raw_w          = RAW_W'(w);
        it.raw_h          = RAW_W'(h);
        it.raw_objectness = RAW_W'(obj);
        it.raw_class      = RAW_W'(cls);
        return it;
    endfunction

    // Mostly cells that pass the confidence filter; the rest is unfiltered noise,
    // including the unused anchor slot.
    function automatic raw_item_t random_cell();
        raw_item_t it;
        int lo;
        it = make_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) != 0) begin
            lo = int'(thr_now);
            it.anchor_slot    = SLOT_W'($urandom_range(0, 2));
            it.raw_objectness = RAW_W'(lo + int'($urandom_range(0, 127 - lo)));
            if (lo < 127)
                it.raw_class = RAW_W'(lo + 1 + int'($urandom_range(0, 126 - lo)));
        end
        return it;
    endfunction

    function automatic logic [59:0] rand_anchors();
        return 60'({$urandom, $urandom});
    endfunction

    function automatic logic [RAW_W-1:0] rand_thresh();
        return RAW_W'(int'($urandom_range(0, 228)) - 128);
    endfunction

    // Offer one input beat after a random gap and wait until it is taken.
    task automatic send_cell(input raw_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.raw_class, it.raw_objectness, it.raw_h, it.raw_w,
                     it.raw_y, it.raw_x, it.grid_col, it.grid_row};
        s_tuser  <= it.anchor_slot;
        do @(posedge aclk); while (!s_tready);
    endtask

    // One register write beat; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [59:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [RAW_W-1:0] zp, input logic [SCALE_W-1:0] scale,
                                 input logic [RAW_W-1:0] thr, input logic [SHIFT_W-1:0] shift,
                                 input logic [ANCHOR_REG_W-1:0] anchors);
        write_reg(CFG_ZERO_POINT, 60'(zp));
        write_reg(CFG_DEQUANT_SCALE, 60'(scale));
        write_reg(CFG_CONF_THRESH, 60'(thr));
        write_reg(CFG_STRIDE_SHIFT, 60'(shift));
        write_reg(CFG_ANCHOR_SIZES, anchors);
        cfg_valid <= 1'b0;
        thr_now = thr;
    endtask

    // Stop sending, let every box come out, then let filtered beats leave the pipe.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls per beat, plus one long hold-off in a dense phase.
    initial begin : result_sink
        int  gap;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (hold_req && !held) begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int p;
        int n;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A couple of beats at the register reset values.
        send_cell(make_cell(3, 4, 0, 20, -20, 50, -50, 10, 12));
        send_cell(make_cell(9, 1, 1, 0, 0, 0, 0, 0, 0));
        drain();

        // Writes to indexes past the register list must change nothing.
        for (n = 1; n <= 3; n++)
            write_reg(3'(CFG_ANCHOR_SIZES) + 3'(n), rand_anchors());

        // Directed beats: field extremes, sigmoid segment boundaries, filters.
        apply_setting(8'd0, 16'd4096, 8'h80, 3'd3,
                      {10'd1023, 10'd1023, 10'd62, 10'd45, 10'd13, 10'd10});
        send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cell(make_cell(127, 127, 2, 127, 127, 127, 127, 127, 127));
        send_cell(make_cell(127, 0, 1, -128, -128, -128, -128, -128, -127));
        send_cell(make_cell(5, 6, 0, 0, 0, 0, 0, 0, -128));
        send_cell(make_cell(3, 3, 3, 10, 10, 10, 10, 10, 10));
        send_cell(make_cell(1, 2, 0, 15, 16, 37, 38, 79, 80));
        send_cell(make_cell(2, 1, 1, -15, -16, -37, -38, -79, -80));
        send_cell(make_cell(64, 64, 2, -1, 1, 100, -100, 1, -1));
        drain();

        // Threshold boundaries: objectness may equal it, class must exceed it.
        apply_setting(8'd0, 16'd4096, 8'd5, 3'd4, rand_anchors());
        send_cell(make_cell(10, 20, 0, 0, 0, 0, 0, 5, 6));
        send_cell(make_cell(10, 20, 1, 0, 0, 0, 0, 4, 6));
        send_cell(make_cell(10, 20, 2, 0, 0, 0, 0, 5, 5));
        send_cell(make_cell(10, 20, 0, 0, 0, 0, 0, 127, 127));
        send_cell(make_cell(10, 20, 1, 0, 0, 0, 0, -128, 127));
        drain();

        // Random phases, each under its own register setting.
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_setting(8'd0, 16'd4096, 8'h80, 3'd3, rand_anchors());
                1: apply_setting(8'h80, 16'hFFFF, rand_thresh(), 3'd7, '1);
                2: apply_setting(8'd127, 16'd1, 8'h80, 3'd0, rand_anchors());
                3: apply_setting(8'($urandom), 16'd0, rand_thresh(), 3'd5, rand_anchors());
                4: apply_setting(8'($urandom), 16'($urandom), 8'd127, 3'd6, '0);
                default: apply_setting(8'($urandom), 16'($urandom_range(1, 65535)),
                                       rand_thresh(), 3'($urandom_range(0, 7)),
                                       rand_anchors());
            endcase
            dense    = (p == 2 || p == 5);
            hold_req = (p == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_cell(random_cell());
            drain();
        end

        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: yolo_anchor_box_decode.f
hw/rtl/yab_pkg.sv
hw/rtl/yab_front.sv
hw/rtl/yab_geom.sv
hw/rtl/yolo_anchor_box_decode.sv
dv/yab_box_checker.sv
dv/tb.sv
